[rtl/core/vlsm_pkg.sv]
// ============================================================================
// vlsm_pkg - shared types, constants and helpers for the VLSM subnet allocator
// Word formats for the request and result channels, sizing constants and a
// small priority encoder used for block sizing and size selection.
// ============================================================================
package vlsm_pkg;

    // Request list depth and derived widths
    localparam int MAX_BLOCKS = 16;
    localparam int POS_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int COUNT_W    = $clog2(MAX_BLOCKS + 1);

    // Field widths fixed by the word formats
    localparam int HOST_W   = 30;
    localparam int ADDR_W   = 32;
    localparam int BITS_W   = 5;
    localparam int INDEX_W  = 4;

    localparam logic [ADDR_W-1:0] ALL_ONES = '1;

    // Request word
    typedef struct packed {
        logic [HOST_W-1:0] host_count;
        logic              last_request;
    } vlsm_req_t;

    // Result word
    typedef struct packed {
        logic [INDEX_W-1:0] block_index;
        logic [ADDR_W-1:0]  network_address;
        logic [ADDR_W-1:0]  first_usable;
        logic [ADDR_W-1:0]  last_usable;
        logic [ADDR_W-1:0]  broadcast_address;
        logic [BITS_W-1:0]  prefix_length;
        logic [ADDR_W-1:0]  subnet_mask;
        logic               last_result;
    } vlsm_res_t;

    // Index of the highest set bit (0 when none set)
    function automatic logic [BITS_W-1:0] high_index(input logic [ADDR_W-1:0] vec);
        logic [BITS_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < ADDR_W; i++)
        begin
            if (vec[i])
                idx = BITS_W'(i);
        end
        return idx;
    endfunction

    // Block size exponent: ceil(log2(hosts + 2)) = bit length of (hosts + 1)
    function automatic logic [BITS_W-1:0] block_bits(input logic [HOST_W-1:0] hosts);
        logic [ADDR_W-1:0] total_m1;
        total_m1 = ADDR_W'(hosts) + ADDR_W'(1);
        return high_index(total_m1) + BITS_W'(1);
    endfunction

endpackage

[rtl/core/vlsm_ram.sv]
// ============================================================================
// vlsm_ram - generic single-write, single-read synchronous RAM
// One write port, one read port with registered read data.
// ============================================================================
module vlsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         clk,
    input  logic                                         wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                             wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                             rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_addr] <= wr_data;
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/vlsm_subnet_allocator_top.sv]
// ============================================================================
// vlsm_subnet_allocator_top - VLSM subnet allocation engine
// Collects host-count requests and, on the last one, emits the allocated
// subnets largest first, packed consecutively from the base address.
// ============================================================================
// Requests load at one word per cycle; each is sized to the smallest 2^bits
// block holding its hosts plus network and broadcast, and the exponent goes
// into a small size RAM (up to MAX_BLOCKS entries; further requests are
// dropped). The word flagged last_request ends the list: the block stops
// taking requests and emits one result per stored entry, largest block
// first, equal sizes in arrival order, starting at base_address (sampled
// when that word is accepted) and wrapping modulo 2^32. Emission walks the
// size RAM once per distinct block size present: it picks the size, then for
// each stored entry reads the RAM and compares, a hit waiting in the compare
// state while the output stalls; the last pass ends as soon as the final
// entry has been emitted.
// Requests are taken again once the final result sits in the output register.
// base_address must be written only while the block is idle.
// ============================================================================
module vlsm_subnet_allocator_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  vlsm_pkg::vlsm_req_t in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output vlsm_pkg::vlsm_res_t out_data,
    input  logic                cfg_write_en,
    input  logic [31:0]         cfg_write_data
);
    import vlsm_pkg::*;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_LOAD  = 4'b0001,
        ST_PICK  = 4'b0010,
        ST_READ  = 4'b0100,
        ST_CHECK = 4'b1000
    } state_t;

    state_t              state_reg,   state_next;
    logic [ADDR_W-1:0]   base_reg;
    logic [COUNT_W-1:0]  count_reg,   count_next;
    logic [COUNT_W-1:0]  emitted_reg, emitted_next;
    logic [ADDR_W-1:0]   size_mask_reg, size_mask_next;
    logic [BITS_W-1:0]   scan_size_reg, scan_size_next;
    logic [POS_W-1:0]    pos_reg,     pos_next;
    logic [ADDR_W-1:0]   addr_reg,    addr_next;
    logic                out_valid_reg, out_valid_next;
    vlsm_res_t           out_word_reg,  out_word_next;

    logic                in_accept;
    logic                list_full;
    logic [BITS_W-1:0]   req_bits;
    logic [BITS_W-1:0]   ram_rd_data;
    logic                out_free;
    logic                hit;
    logic [ADDR_W-1:0]   low_mask;
    logic [ADDR_W-1:0]   bcast;
    logic [ADDR_W-1:0]   last_use;
    logic                pass_done;
    logic                run_done;

    // Handshake
    assign in_stall  = (state_reg != ST_LOAD);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign list_full = (count_reg == COUNT_W'(MAX_BLOCKS));
    assign req_bits  = block_bits(in_data.host_count);

    // Size store
    vlsm_ram #(
        .WIDTH (BITS_W),
        .DEPTH (MAX_BLOCKS)
    ) u_size_ram (
        .clk     (clk),
        .wr_en   (in_accept && !list_full),
        .wr_addr (count_reg[POS_W-1:0]),
        .wr_data (req_bits),
        .rd_addr (pos_reg),
        .rd_data (ram_rd_data)
    );

    // Result arithmetic for the entry under test
    assign low_mask  = ~(ALL_ONES << scan_size_reg);
    assign bcast     = addr_reg + low_mask;
    assign last_use  = addr_reg + (low_mask - ADDR_W'(1));
    assign hit       = (ram_rd_data == scan_size_reg);
    assign pass_done = ({1'b0, pos_reg} == (COUNT_W'(count_reg) - COUNT_W'(1)));
    assign run_done  = ((emitted_reg + COUNT_W'(1)) == count_reg);

    // Next-state logic
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        emitted_next   = emitted_reg;
        size_mask_next = size_mask_reg;
        scan_size_next = scan_size_reg;
        pos_next       = pos_reg;
        addr_next      = addr_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_word_next  = out_word_reg;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_accept)
                begin
                    if (!list_full)
                    begin
                        count_next               = count_reg + COUNT_W'(1);
                        size_mask_next[req_bits] = 1'b1;
                    end
                    if (in_data.last_request)
                    begin
                        addr_next  = base_reg;
                        state_next = ST_PICK;
                    end
                end
            end
            ST_PICK:
            begin
                scan_size_next                 = high_index(size_mask_reg);
                size_mask_next[scan_size_next] = 1'b0;
                pos_next                       = '0;
                state_next                     = ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (hit && !out_free)
                begin
                    state_next = ST_CHECK;
                end
                else
                begin
                    if (hit)
                    begin
                        out_valid_next                  = 1'b1;
                        out_word_next.block_index       = INDEX_W'(pos_reg);
                        out_word_next.network_address   = addr_reg;
                        out_word_next.first_usable      = addr_reg + ADDR_W'(1);
                        out_word_next.last_usable       = last_use;
                        out_word_next.broadcast_address = bcast;
                        out_word_next.prefix_length     =
                            BITS_W'(6'd32 - {1'b0, scan_size_reg});
                        out_word_next.subnet_mask       = ~low_mask;
                        out_word_next.last_result       = run_done;
                        addr_next                       = bcast + ADDR_W'(1);
                        emitted_next                    = emitted_reg + COUNT_W'(1);
                    end
                    priority if (hit && run_done)
                    begin
                        // final result: list empties, back to loading
                        count_next     = '0;
                        emitted_next   = '0;
                        size_mask_next = '0;
                        pos_next       = '0;
                        state_next     = ST_LOAD;
                    end
                    else if (pass_done)
                    begin
                        state_next = ST_PICK;
                    end
                    else
                    begin
                        pos_next   = pos_reg + POS_W'(1);
                        state_next = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            base_reg      <= '0;
            count_reg     <= '0;
            emitted_reg   <= '0;
            size_mask_reg <= '0;
            scan_size_reg <= '0;
            pos_reg       <= '0;
            addr_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            emitted_reg   <= emitted_next;
            size_mask_reg <= size_mask_next;
            scan_size_reg <= scan_size_next;
            pos_reg       <= pos_next;
            addr_reg      <= addr_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write_en)
                base_reg <= cfg_write_data;
        end
    end

    // Output word register
    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;

endmodule
